// ----- hdl/nss_pkg.sv -----
// Shared types and constants for the NFA state-set stepper.
`default_nettype none

package nss_pkg;

    // Width of one word of a reach class and of an input class.
    localparam int unsigned CLASS_WORD_W = 64;
    // Number of words that make up a 256-bit class.
    localparam int unsigned CLASS_WORDS  = 4;

    // Item commands.
    typedef enum logic [1:0] {
        CMD_LOAD_SUCC   = 2'd0,
        CMD_LOAD_REACH  = 2'd1,
        CMD_LOAD_ACTIVE = 2'd2,
        CMD_STEP        = 2'd3
    } cmd_t;

    // One input beat.
    typedef struct packed {
        cmd_t        cmd;
        logic [4:0]  state_index;
        logic [1:0]  word_index;
        logic [63:0] load_value;
        logic [63:0] class_word_0;
        logic [63:0] class_word_1;
        logic [63:0] class_word_2;
        logic [63:0] class_word_3;
    } in_item_t;

    // One result beat.
    typedef struct packed {
        logic [31:0] active_states;
        logic        dead;
    } out_item_t;

    // A full 256-bit class, one entry per word.
    typedef logic [CLASS_WORDS-1:0][CLASS_WORD_W-1:0] class_t;

    // Table write controls from the sequencer.
    typedef struct packed {
        logic                    succ_we;
        logic                    reach_we;
        logic [1:0]              word;
        logic [CLASS_WORD_W-1:0] data;
    } tbl_wr_t;

    // Control of the shared step unit.
    typedef struct packed {
        logic start;
        logic consume;
        logic finish;
        logic load_active;
        logic kill;
    } unit_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/nss_tables.sv -----
// Successor and reach table memories with one write port and a registered read port.
`default_nettype none

module nss_tables #(
    parameter int NUM_STATES = 32
) (
    input  wire logic                        clk,
    input  wire nss_pkg::tbl_wr_t            wr,
    input  wire logic [$clog2(NUM_STATES)-1:0] waddr,
    input  wire logic [$clog2(NUM_STATES)-1:0] raddr,
    output logic [NUM_STATES-1:0]            succ_row,
    output nss_pkg::class_t                  reach_row
);

    logic [NUM_STATES-1:0] succ_mem [NUM_STATES];

    // Successor rows: one row per state.
    always_ff @(posedge clk)
    begin
        if (wr.succ_we)
        begin
            succ_mem[waddr] <= wr.data[NUM_STATES-1:0];
        end
        succ_row <= succ_mem[raddr];
    end

    // Reach class kept as one bank per word, all read at the same state.
    for (genvar w = 0; w < nss_pkg::CLASS_WORDS; w++)
    begin : g_bank
        logic [nss_pkg::CLASS_WORD_W-1:0] reach_mem [NUM_STATES];

        always_ff @(posedge clk)
        begin
            if (wr.reach_we && (wr.word == 2'(w)))
            begin
                reach_mem[waddr] <= wr.data;
            end
            reach_row[w] <= reach_mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/nss_step_unit.sv -----
// Shared step unit: folds one successor row and one reach test per cycle into the next set.
`default_nettype none

module nss_step_unit #(
    parameter int NUM_STATES          = 32,
    parameter int START_DOTSTAR_INDEX = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nss_pkg::unit_ctrl_t   ctrl,
    input  wire logic [NUM_STATES-1:0] load_value,
    input  wire logic [NUM_STATES-1:0] succ_row,
    input  wire nss_pkg::class_t       reach_row,
    input  wire nss_pkg::class_t       class_in,
    output logic [NUM_STATES-1:0]      active_set
);

    // Bit of the start-dotstar state, empty when it lies beyond the state count.
    localparam logic [NUM_STATES-1:0] DOTSTAR_BIT =
        (START_DOTSTAR_INDEX < NUM_STATES) ?
        (NUM_STATES'(1) << START_DOTSTAR_INDEX) : '0;

    logic [NUM_STATES-1:0] active_reg, active_next;
    logic [NUM_STATES-1:0] scan_reg, scan_next;
    logic [NUM_STATES-1:0] acc_reg, acc_next;
    logic [NUM_STATES-1:0] hit_reg, hit_next;
    logic                  hit;

    // Reach test of the current state against the held class.
    always_comb
    begin
        hit = 1'b0;
        for (int w = 0; w < nss_pkg::CLASS_WORDS; w++)
        begin
            hit = hit | (|(reach_row[w] & class_in[w]));
        end
    end

    // Scan, accumulate, final filtering and active-set load.
    always_comb
    begin
        scan_next   = scan_reg;
        acc_next    = acc_reg;
        hit_next    = hit_reg;
        active_next = active_reg;
        if (ctrl.start)
        begin
            scan_next = active_reg;
            acc_next  = '0;
        end
        else if (ctrl.consume)
        begin
            scan_next = scan_reg >> 1;
            acc_next  = acc_reg | (scan_reg[0] ? succ_row : '0);
            hit_next  = {hit, hit_reg[NUM_STATES-1:1]};
        end
        if (ctrl.load_active)
        begin
            active_next = load_value;
        end
        else if (ctrl.finish)
        begin
            active_next = acc_reg & hit_reg & ~(ctrl.kill ? DOTSTAR_BIT : '0);
        end
    end

    // Active set is control state; the scan registers are payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        acc_reg  <= acc_next;
        hit_reg  <= hit_next;
    end

    assign active_set = active_reg;

endmodule

`default_nettype wire

// ----- hdl/nfa_state_set_stepper_top.sv -----
// Top level of the NFA state-set stepper: handshakes, sequencer and configuration.
// Load items: the sequencer goes from idle to emit, and the result beat is registered from there.
// Step items: the sequencer walks the tables, then passes the tail and final states to emit,
// and the result beat is registered from there; the shared step unit visits one state's
// successor row and reach class per cycle. One item is in work at a time; a new item is
// taken while a result beat waits, and its own result then waits in emit until that beat is taken.
// Reset clears the active set, the kill register and handshake state; tables are undefined.
`default_nettype none

module nfa_state_set_stepper_top #(
    parameter int NUM_STATES          = 32,
    parameter int START_DOTSTAR_INDEX = 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire nss_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output nss_pkg::out_item_t     out_data
);

    localparam int AW    = $clog2(NUM_STATES);
    localparam int CW    = $clog2(NUM_STATES + 1);
    localparam int IDX_W = (CW > 5) ? CW : 5;
    localparam int EXT_W = (NUM_STATES > 32) ? NUM_STATES : 32;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_WALK  = 5'b00010,
        ST_TAIL  = 5'b00100,
        ST_FINAL = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         cnt_reg, cnt_next;
    logic                  rd_valid_reg;
    logic                  kill_reg;
    nss_pkg::class_t       class_reg;
    logic                  out_valid_reg;
    nss_pkg::out_item_t    out_data_reg;

    logic                  accept;
    logic                  out_free;
    logic [IDX_W-1:0]      sidx_ext;
    logic                  sidx_ok;
    nss_pkg::tbl_wr_t      tbl_wr;
    nss_pkg::unit_ctrl_t   unit_ctrl;
    logic [NUM_STATES-1:0] succ_row;
    nss_pkg::class_t       reach_row;
    logic [NUM_STATES-1:0] active_set;
    logic [EXT_W-1:0]      active_ext;

    // Input handshake.
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Table writes happen on the accepting edge.
    assign sidx_ext = IDX_W'(in_data.state_index);
    assign sidx_ok  = (sidx_ext < IDX_W'(NUM_STATES));

    always_comb
    begin
        tbl_wr.succ_we  = accept && (in_data.cmd == nss_pkg::CMD_LOAD_SUCC) && sidx_ok;
        tbl_wr.reach_we = accept && (in_data.cmd == nss_pkg::CMD_LOAD_REACH) && sidx_ok;
        tbl_wr.word     = in_data.word_index;
        tbl_wr.data     = in_data.load_value;
    end

    // Step unit controls.
    always_comb
    begin
        unit_ctrl.start       = accept && (in_data.cmd == nss_pkg::CMD_STEP);
        unit_ctrl.consume     = rd_valid_reg;
        unit_ctrl.finish      = (state_reg == ST_FINAL);
        unit_ctrl.load_active = accept && (in_data.cmd == nss_pkg::CMD_LOAD_ACTIVE);
        unit_ctrl.kill        = kill_reg;
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (accept)
                begin
                    state_next = (in_data.cmd == nss_pkg::CMD_STEP) ? ST_WALK : ST_EMIT;
                end
            end
            ST_WALK:
            begin
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == AW'(NUM_STATES - 1))
                begin
                    state_next = ST_TAIL;
                end
            end
            ST_TAIL:
            begin
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            kill_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= (state_reg == ST_WALK);
            if (cfg_we)
            begin
                kill_reg <= cfg_wdata;
            end
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Held class of a step item and the result beat register.
    assign active_ext = EXT_W'(active_set);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            class_reg[0] <= in_data.class_word_0;
            class_reg[1] <= in_data.class_word_1;
            class_reg[2] <= in_data.class_word_2;
            class_reg[3] <= in_data.class_word_3;
        end
        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_data_reg.active_states <= active_ext[31:0];
            out_data_reg.dead          <= (active_set == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    nss_tables #(
        .NUM_STATES (NUM_STATES)
    ) u_tables (
        .clk       (clk),
        .wr        (tbl_wr),
        .waddr     (sidx_ext[AW-1:0]),
        .raddr     (cnt_reg),
        .succ_row  (succ_row),
        .reach_row (reach_row)
    );

    nss_step_unit #(
        .NUM_STATES          (NUM_STATES),
        .START_DOTSTAR_INDEX (START_DOTSTAR_INDEX)
    ) u_step_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (unit_ctrl),
        .load_value (in_data.load_value[NUM_STATES-1:0]),
        .succ_row   (succ_row),
        .reach_row  (reach_row),
        .class_in   (class_reg),
        .active_set (active_set)
    );

`ifndef SYNTHESIS
    // The sequencer holds exactly one state.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state is not one-hot");

    // An accepted step beat starts the table walk.
    a_step_walks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_data.cmd == nss_pkg::CMD_STEP)) |=> (state_reg == ST_WALK))
        else $error("step beat did not start the walk");

    // The walk always starts at state zero.
    a_walk_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WALK) && !$past(state_reg == ST_WALK)) |-> (cnt_reg == '0))
        else $error("walk did not start at state zero");

    // A result beat only appears after the emit state.
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result beat raised outside emit");
`endif

endmodule

`default_nettype wire

// ----- tb/nfa_state_set_stepper_top_test.sv -----
// Self-checking testbench for the NFA state-set stepper: table-driven directed beats, then random.
`timescale 1ns / 100ps

module nfa_state_set_stepper_top_test;

    localparam int N_STATES       = 32;
    localparam int DOTSTAR_IDX    = 1;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int STEP_CYCLES    = N_STATES + 4;
    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 160;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [63:0] ALL1  = '1;
    localparam logic [63:0] W_TOP = 64'h8000_0000_0000_0000;

    // One row of the directed table; act and dead hold a typed-in result when typed is set.
    typedef struct {
        bit            kill;
        nss_pkg::cmd_t cmd;
        logic [4:0]    si;
        logic [1:0]    wi;
        logic [63:0]   val;
        logic [63:0]   c0;
        logic [63:0]   c1;
        logic [63:0]   c2;
        logic [63:0]   c3;
        bit            typed;
        logic [31:0]   act;
        logic          dead;
    } dir_row_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    nss_pkg::in_item_t  in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    nss_pkg::out_item_t out_data;

    // Predicted NFA tables, active set and kill setting.
    logic [31:0] succ_rows   [N_STATES];
    logic [63:0] reach_words [N_STATES][4];
    logic [31:0] act_set     = '0;
    logic        kill_dotstar = 1'b0;

    nss_pkg::out_item_t expected_sets [$];
    dir_row_t           dir_rows [$];
    nss_pkg::out_item_t want;

    int          err_count   = 0;
    int          n_items     = 0;
    int          n_steps     = 0;
    int          n_cfg       = 0;
    int          n_checked   = 0;
    int          n_dead      = 0;
    int unsigned quiet_in    = 0;
    int unsigned hold_left   = 0;
    int unsigned calm_left   = 0;
    int unsigned quiet_cycles = 0;

    nfa_state_set_stepper_top #(
        .NUM_STATES          (N_STATES),
        .START_DOTSTAR_INDEX (DOTSTAR_IDX)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // Successor union of the active states, start-dotstar kill, then the reach filter.
    function automatic logic [31:0] next_states(input nss_pkg::in_item_t it);
        logic [31:0] nxt;
        logic [63:0] hit;
        nxt = '0;
        for (int s = 0; s < N_STATES; s++)
        begin
            if (act_set[s])
                nxt |= succ_rows[s];
        end
        if (kill_dotstar && DOTSTAR_IDX < N_STATES)
            nxt[DOTSTAR_IDX] = 1'b0;
        for (int s = 0; s < N_STATES; s++)
        begin
            hit = (reach_words[s][0] & it.class_word_0) | (reach_words[s][1] & it.class_word_1)
                | (reach_words[s][2] & it.class_word_2) | (reach_words[s][3] & it.class_word_3);
            if (nxt[s] && hit == 64'd0)
                nxt[s] = 1'b0;
        end
        return nxt;
    endfunction

    // Updates the predicted state for one beat and returns the result it should produce.
    function automatic nss_pkg::out_item_t apply_item(input nss_pkg::in_item_t it);
        nss_pkg::out_item_t res;
        case (it.cmd)
            nss_pkg::CMD_LOAD_SUCC:   succ_rows[it.state_index] = it.load_value[31:0];
            nss_pkg::CMD_LOAD_REACH:  reach_words[it.state_index][it.word_index] = it.load_value;
            nss_pkg::CMD_LOAD_ACTIVE: act_set = it.load_value[31:0];
            default:                  act_set = next_states(it);
        endcase
        res.active_states = act_set;
        res.dead          = (act_set == '0);
        return res;
    endfunction

    function automatic dir_row_t dir_row(input bit kill, input nss_pkg::cmd_t cmd,
                                         input logic [4:0] si, input logic [1:0] wi,
                                         input logic [63:0] val,
                                         input logic [63:0] c0, input logic [63:0] c1,
                                         input logic [63:0] c2, input logic [63:0] c3,
                                         input bit typed, input logic [31:0] act,
                                         input logic dead);
        dir_row_t r;
        r.kill = kill; r.cmd = cmd; r.si = si; r.wi = wi; r.val = val;
        r.c0 = c0; r.c1 = c1; r.c2 = c2; r.c3 = c3;
        r.typed = typed; r.act = act; r.dead = dead;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sparse successor rows keep the active set from filling up at once.
    function automatic logic [31:0] sparse32();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom & $urandom & $urandom;
        endcase
    endfunction

    function automatic logic [63:0] class_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL1;
            2:       return 64'd1 << $urandom_range(0, 63);
            3:       return {$urandom & $urandom & $urandom, $urandom & $urandom & $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] reach_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL1;
            2:       return {$urandom & $urandom, $urandom & $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [63:0] active_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Random beat: mostly steps, with loads of every kind mixed in; unused fields are noise.
    function automatic nss_pkg::in_item_t rand_item();
        nss_pkg::in_item_t it;
        int unsigned       r;
        it.state_index  = 5'($urandom_range(0, 31));
        it.word_index   = 2'($urandom_range(0, 3));
        it.load_value   = {$urandom, $urandom};
        it.class_word_0 = class_word();
        it.class_word_1 = class_word();
        it.class_word_2 = class_word();
        it.class_word_3 = class_word();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            it.cmd        = nss_pkg::CMD_LOAD_SUCC;
            it.load_value = {$urandom, sparse32()};
        end
        else if (r < 20)
        begin
            it.cmd        = nss_pkg::CMD_LOAD_REACH;
            it.load_value = reach_word();
        end
        else if (r < 30)
        begin
            it.cmd        = nss_pkg::CMD_LOAD_ACTIVE;
            it.load_value = active_word();
        end
        else
            it.cmd = nss_pkg::CMD_STEP;
        return it;
    endfunction

    // Presents one beat, holds it until accepted, then queues its expected result.
    task automatic send_item(input nss_pkg::in_item_t it, input bit typed,
                             input logic [31:0] act, input logic dead);
        nss_pkg::out_item_t res;
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = apply_item(it);
        if (typed)
        begin
            res.active_states = act;
            res.dead          = dead;
        end
        expected_sets.push_back(res);
        n_items++;
        if (it.cmd == nss_pkg::CMD_STEP)
            n_steps++;
    endtask

    // Sender gap after a beat, with stretches of back-to-back beats.
    task automatic pace();
        int unsigned g;
        if (quiet_in != 0)
        begin
            quiet_in--;
            g = 0;
        end
        else
        begin
            if ($urandom_range(0, 99) < 2)
                quiet_in = $urandom_range(20, 60);
            g = idle_len();
        end
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Holds off the sender until every expected result has come and the block is idle.
    task automatic drain_pause();
        in_valid <= 1'b0;
        while (expected_sets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_kill(input logic v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we       <= 1'b0;
        kill_dotstar = v;
        n_cfg++;
    endtask

    // Receiver stalls of random length, with stretches of no stall.
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            if (calm_left != 0)
                calm_left <= calm_left - 1;
            else if ($urandom_range(0, 99) < 2)
                calm_left <= $urandom_range(30, 80);
            else if ($urandom_range(0, 2) == 0)
                hold_left <= idle_len();
        end
    end

    // Result checker: each accepted beat against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_sets.size() == 0)
            begin
                $display("%0t: result beat with nothing expected: active_states %h dead %b",
                         $time, out_data.active_states, out_data.dead);
                err_count++;
            end
            else
            begin
                want = expected_sets.pop_front();
                if (out_data.active_states !== want.active_states)
                begin
                    $display("%0t: active_states mismatch: expected %h, actual %h",
                             $time, want.active_states, out_data.active_states);
                    err_count++;
                end
                if (out_data.dead !== want.dead)
                begin
                    $display("%0t: dead mismatch: expected %b, actual %b",
                             $time, want.dead, out_data.dead);
                    err_count++;
                end
                n_checked++;
                if (want.dead)
                    n_dead++;
            end
        end
    end

    // Watchdog: ends the run when no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
            $display("nfa_state_set_stepper_top_test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        nss_pkg::in_item_t it;
        dir_row_t          row;

        // Directed table: reset state, masking, extremes, kill and the empty set.
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_SUCC, 5'd0, 2'd0, 64'd0,
                                   ALL1, ALL1, ALL1, ALL1, 1, 32'd0, 1'b1));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_STEP, 5'd31, 2'd3, ALL1,
                                   ALL1, ALL1, ALL1, ALL1, 1, 32'd0, 1'b1));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0,
                                   64'hFFFF_FFFF_0000_0000,
                                   '0, '0, '0, '0, 1, 32'd0, 1'b1));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, ALL1,
                                   '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_SUCC, 5'd31, 2'd3, ALL1,
                                   '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_SUCC, 5'd0, 2'd0,
                                   64'hFFFF_FFFF_0000_0006,
                                   '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_REACH, 5'd31, 2'd3, ALL1,
                                   '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        for (int w = 0; w < 4; w++)
            dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_REACH, 5'd1, w[1:0],
                                       (w == 0) ? 64'd1 : 64'd0,
                                       '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        for (int w = 0; w < 4; w++)
            dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_REACH, 5'd2, w[1:0],
                                       (w == 3) ? W_TOP : 64'd0,
                                       '0, '0, '0, '0, 1, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, 64'd1,
                                   '0, '0, '0, '0, 1, 32'd1, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_STEP, 5'd0, 2'd0, '0,
                                   ALL1, ALL1, ALL1, ALL1, 0, '0, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, 64'd1,
                                   '0, '0, '0, '0, 1, 32'd1, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_STEP, 5'd0, 2'd0, '0,
                                   '0, '0, '0, W_TOP, 0, '0, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, 64'd1,
                                   '0, '0, '0, '0, 1, 32'd1, 1'b0));
        dir_rows.push_back(dir_row(0, nss_pkg::CMD_STEP, 5'd0, 2'd0, ALL1,
                                   '0, '0, '0, '0, 1, 32'd0, 1'b1));
        dir_rows.push_back(dir_row(1, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, 64'd1,
                                   '0, '0, '0, '0, 1, 32'd1, 1'b0));
        dir_rows.push_back(dir_row(1, nss_pkg::CMD_STEP, 5'd0, 2'd0, '0,
                                   ALL1, ALL1, ALL1, ALL1, 0, '0, 1'b0));
        dir_rows.push_back(dir_row(1, nss_pkg::CMD_LOAD_ACTIVE, 5'd0, 2'd0, 64'd1,
                                   '0, '0, '0, '0, 1, 32'd1, 1'b0));
        dir_rows.push_back(dir_row(1, nss_pkg::CMD_STEP, 5'd0, 2'd0, '0,
                                   64'd1, '0, '0, '0, 0, '0, 1'b0));
        dir_rows.push_back(dir_row(1, nss_pkg::CMD_STEP, 5'd0, 2'd0, '0,
                                   ALL1, ALL1, ALL1, ALL1, 1, 32'd0, 1'b1));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part; the kill register changes only once the block is idle.
        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            if (row.kill != kill_dotstar)
            begin
                drain_pause();
                write_kill(row.kill);
            end
            it.cmd          = row.cmd;
            it.state_index  = row.si;
            it.word_index   = row.wi;
            it.load_value   = row.val;
            it.class_word_0 = row.c0;
            it.class_word_1 = row.c1;
            it.class_word_2 = row.c2;
            it.class_word_3 = row.c3;
            send_item(it, row.typed, row.act, row.dead);
            pace();
        end

        // Fill every successor row and reach word so that any later step reads written entries.
        for (int s = 0; s < N_STATES; s++)
        begin
            it            = rand_item();
            it.cmd        = nss_pkg::CMD_LOAD_SUCC;
            it.state_index = 5'(s);
            it.load_value = {$urandom, sparse32()};
            send_item(it, 0, '0, 1'b0);
            pace();
            for (int w = 0; w < 4; w++)
            begin
                it             = rand_item();
                it.cmd         = nss_pkg::CMD_LOAD_REACH;
                it.state_index = 5'(s);
                it.word_index  = 2'(w);
                it.load_value  = reach_word();
                send_item(it, 0, '0, 1'b0);
                pace();
            end
        end

        // Random phases, alternating the kill setting between its two values.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_pause();
            write_kill(p[0]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_item(rand_item(), 0, '0, 1'b0);
                if ($urandom_range(0, 99) == 0)
                    drain_pause();
                else
                    pace();
            end
        end

        // Let every result come home, then give the block time for stray beats.
        in_valid <= 1'b0;
        while (expected_sets.size() != 0)
            @(posedge clk);
        repeat (STEP_CYCLES + SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d input beats (%0d steps) across %0d kill register writes.",
                 n_items, n_steps, n_cfg);
        $display("Checked %0d result beats, %0d of them with an empty active set.",
                 n_checked, n_dead);
        if (err_count == 0)
            $display("nfa_state_set_stepper_top_test passed");
        else
            $display("nfa_state_set_stepper_top_test failed");
        $finish;
    end

endmodule
